/* src/tbrc_pkg.sv */
// ----------------------------------------------------------------------------
// tbrc_pkg
// Shared constants, types and helpers of the typed bracket range checker.
// ----------------------------------------------------------------------------
package tbrc_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int TOKEN_BITS  = 16;
	localparam int INDEX_BITS  = 10;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int DEPTH_W     = IDX_W + 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                  clear;
		logic                  push;
		logic                  pop;
		logic [TOKEN_BITS-1:0] value;
	} stk_op_t;

	typedef struct packed {
		logic                  empty;
		logic                  one;
		logic [TOKEN_BITS-1:0] top;
	} stk_stat_t;

	function automatic logic [IDX_W-1:0] wrap_idx(input logic [INDEX_BITS-1:0] i);
		return IDX_W'(i % STORE_DEPTH);
	endfunction

endpackage

/* src/tbrc_ram.sv */
// ----------------------------------------------------------------------------
// tbrc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tbrc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/tbrc_stack.sv */
// ----------------------------------------------------------------------------
// tbrc_stack
// Type stack held in a RAM; top of stack from a register after a push,
// from the RAM read issued at the pop otherwise.
// ----------------------------------------------------------------------------
module tbrc_stack (
	input  logic               clk,
	input  logic               arst_n,
	input  tbrc_pkg::stk_op_t  op,
	output tbrc_pkg::stk_stat_t stat
);
	import tbrc_pkg::*;

	logic [DEPTH_W-1:0]    depth_q;
	logic [TOKEN_BITS-1:0] top_q;
	logic                  top_sel_q;
	logic [TOKEN_BITS-1:0] rd_data;
	logic [DEPTH_W-1:0]    below_top;
	logic                  wr_en;

	// entry under the current top becomes the new top after a pop
	assign below_top = depth_q - DEPTH_W'(2);
	assign wr_en     = op.push && (depth_q < DEPTH_W'(STORE_DEPTH));

	tbrc_ram #(
		.DEPTH(STORE_DEPTH),
		.WIDTH(TOKEN_BITS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(depth_q[IDX_W-1:0]),
		.wdata(op.value),
		.raddr(below_top[IDX_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			top_sel_q <= 1'b0;
		end else if (op.clear) begin
			depth_q   <= '0;
			top_sel_q <= 1'b0;
		end else if (op.push) begin
			depth_q   <= depth_q + DEPTH_W'(1);
			top_sel_q <= 1'b0;
		end else if (op.pop) begin
			depth_q   <= depth_q - DEPTH_W'(1);
			top_sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q <= op.value;
		end
	end

	assign stat.empty = (depth_q == '0);
	assign stat.one   = (depth_q == DEPTH_W'(1));
	assign stat.top   = top_sel_q ? rd_data : top_q;

endmodule

/* src/typed_bracket_range_checker.sv */
// ----------------------------------------------------------------------------
// typed_bracket_range_checker
// Token store with range queries that check typed bracket matching.
// ----------------------------------------------------------------------------
// write: no result; busy stays low
// query over n tokens: busy through ST_WALK and ST_DRAIN, done strobes after
//   ST_DRAIN (or at a mismatch), next beat once busy is low; the walk reads
//   one token per cycle through the token RAM read port
// empty range: done in the cycle after the accept, busy stays low
// reset clears control only; the token store is undefined until written
module typed_bracket_range_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [tbrc_pkg::INDEX_BITS-1:0]     first_index,
	input  logic [tbrc_pkg::INDEX_BITS-1:0]     last_index,
	input  logic signed [tbrc_pkg::TOKEN_BITS-1:0] token,
	output logic                                done,
	output logic                                balanced
);
	import tbrc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]            state_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [IDX_W-1:0]      hi_q;
	logic                  rd_vld_s1;
	logic                  last_s1;
	logic                  done_q;
	logic                  balanced_q;

	logic                  accept;
	logic                  wr_tok;
	logic [IDX_W-1:0]      lo_w;
	logic [IDX_W-1:0]      hi_w;
	logic [TOKEN_BITS-1:0] tok_rd;
	logic [TOKEN_BITS:0]   neg_tok;
	logic [TOKEN_BITS:0]   top_ext;
	logic                  proc;
	logic                  is_close;
	logic                  match;
	logic                  fail;
	stk_op_t               sop;
	stk_stat_t             sst;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_tok = accept && (cmd == CMD_WRITE);
	assign lo_w   = wrap_idx(first_index);
	assign hi_w   = wrap_idx(last_index);

	tbrc_ram #(
		.DEPTH(STORE_DEPTH),
		.WIDTH(TOKEN_BITS)
	) u_store (
		.clk  (clk),
		.we   (wr_tok),
		.waddr(lo_w),
		.wdata(token),
		.raddr(ptr_q),
		.rdata(tok_rd)
	);

	tbrc_stack u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (sop),
		.stat  (sst)
	);

	// closer matches when its magnitude equals the open type on top
	assign neg_tok  = -{tok_rd[TOKEN_BITS-1], tok_rd};
	assign top_ext  = {sst.top[TOKEN_BITS-1], sst.top};
	assign proc     = rd_vld_s1 && busy;
	assign is_close = tok_rd[TOKEN_BITS-1];
	assign match    = !sst.empty && (top_ext == neg_tok);
	assign fail     = proc && is_close && !match;

	always_comb begin
		sop.clear = accept && (cmd == CMD_QUERY);
		sop.push  = proc && !is_close;
		sop.pop   = proc && is_close && match;
		sop.value = tok_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept && (cmd == CMD_QUERY)) begin
						if (lo_w > hi_w) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (fail) begin
						done_q    <= 1'b1;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						rd_vld_s1 <= 1'b1;
						if (ptr_q == hi_q) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// last token is in the read stage here
					rd_vld_s1 <= 1'b0;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ptr_q      <= lo_w;
			hi_q       <= hi_w;
			balanced_q <= 1'b1;
		end else if (state_q == ST_WALK) begin
			ptr_q   <= ptr_q + IDX_W'(1);
			last_s1 <= (ptr_q == hi_q);
		end
		if (fail) begin
			balanced_q <= 1'b0;
		end else if (proc && last_s1) begin
			balanced_q <= sop.pop && sst.one;
		end
	end

	assign done     = done_q;
	assign balanced = balanced_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a walk is still running");

	a_no_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !rd_vld_s1 || $past(busy))
		else $error("token read stage live while idle");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_WRITE) |=> !done && !busy)
		else $error("write beat produced a result or started a walk");

	a_query_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_QUERY && lo_w <= hi_w) |=> busy && !done)
		else $error("non-empty query did not start a walk");

endmodule
